@@ rtl/aie_pkg.sv @@
// Shared types, opcodes and defaults for the accumulator instruction executor.
package aie_pkg;

  localparam int WORD_W              = 32;
  localparam int STEP_CNT_W          = 5;
  localparam int VARIABLE_COUNT_DEF  = 32;
  localparam int PROGRAM_DEPTH_DEF   = 256;
  localparam int VAR_INDEX_W         = 5;
  localparam int VAR_INDEX_CODES     = 32;
  localparam int TARGET_W            = 8;
  localparam int TARGET_CODES        = 256;

  typedef enum logic [3:0] {
    OP_LOAD  = 4'd0,
    OP_STORE = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MULT  = 4'd4,
    OP_DIV   = 4'd5,
    OP_BG    = 4'd6,
    OP_BE    = 4'd7,
    OP_BL    = 4'd8,
    OP_BU    = 4'd9,
    OP_READ  = 4'd10,
    OP_PRINT = 4'd11,
    OP_DC    = 4'd12,
    OP_END   = 4'd13
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_RUN  = 2'd0,
    STAT_END  = 2'd1,
    STAT_BADOP = 2'd2,
    STAT_DIV0 = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [3:0]               opcode;
    logic                     use_immediate;
    logic signed [WORD_W-1:0] immediate_value;
    logic [VAR_INDEX_W-1:0]   var_index;
    logic [TARGET_W-1:0]      branch_target;
    logic signed [WORD_W-1:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic [TARGET_W-1:0]      next_pc;
    logic signed [WORD_W-1:0] acc_value;
    logic                     print_valid;
    logic signed [WORD_W-1:0] print_value;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic              is_div;
    logic [WORD_W-1:0] op_a;
    logic [WORD_W-1:0] op_b;
  } md_req_t;

endpackage

@@ rtl/aie_muldiv.sv @@
// Shared iterative multiplier and signed truncating divider, one bit per cycle.
module aie_muldiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  aie_pkg::md_req_t              req,
  output logic                          done,
  output logic [aie_pkg::WORD_W-1:0]    result
);

  localparam int W = aie_pkg::WORD_W;

  logic                            busy_r;
  logic                            done_r;
  logic                            is_div_r;
  logic                            neg_r;
  logic [aie_pkg::STEP_CNT_W-1:0]  cnt_r;
  logic [W-1:0]                    a_r;
  logic [W-1:0]                    b_r;
  logic [W-1:0]                    res_r;
  logic [W-1:0]                    rem_r;

  logic [W-1:0] a_mag;
  logic [W-1:0] b_mag;
  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic [W-1:0] prod_nxt;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] q_nxt;

  assign a_mag    = req.op_a[W-1] ? (W'(0) - req.op_a) : req.op_a;
  assign b_mag    = req.op_b[W-1] ? (W'(0) - req.op_b) : req.op_b;
  assign rem_sh   = {rem_r, res_r[W-1]};
  assign diff     = rem_sh - {1'b0, b_r};
  assign prod_nxt = res_r + (b_r[0] ? a_r : W'(0));
  assign rem_nxt  = diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
  assign q_nxt    = {res_r[W-2:0], ~diff[W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '1);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div_r <= req.is_div;
      neg_r    <= req.op_a[W-1] ^ req.op_b[W-1];
      rem_r    <= '0;
      if (req.is_div) begin
        a_r   <= req.op_a;
        b_r   <= b_mag;
        res_r <= a_mag;
      end else begin
        a_r   <= req.op_a;
        b_r   <= req.op_b;
        res_r <= '0;
      end
    end else if (busy_r) begin
      if (is_div_r) begin
        rem_r <= rem_nxt;
        res_r <= q_nxt;
      end else begin
        res_r <= prod_nxt;
        a_r   <= {a_r[W-2:0], 1'b0};
        b_r   <= {1'b0, b_r[W-1:1]};
      end
    end
  end

  assign done   = done_r;
  assign result = (is_div_r && neg_r) ? (W'(0) - res_r) : res_r;

endmodule

@@ rtl/accumulator_instruction_executor.sv @@
// Top level: accumulator machine executor with variable store memory and control.
//
// Each accepted input transaction executes one decoded instruction and yields exactly one
// result transaction. Load, store, add, sub, branches, read, print, define-constant and end
// pass through the execute and output-load states before their result is presented;
// multiply and divide wait between them for the shared iterative unit, which resolves
// one bit per cycle. The output-load state holds while the output register is still full
// and not taken. Items are processed one at a time; the next transaction is accepted while
// a result still waits in the output register. After reset, the variable store is zeroed
// by a clearing pass over all VARIABLE_COUNT entries, during which in_ready stays low.
module accumulator_instruction_executor #(
  parameter int VARIABLE_COUNT = aie_pkg::VARIABLE_COUNT_DEF,
  parameter int PROGRAM_DEPTH  = aie_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aie_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aie_pkg::out_item_t out_data
);

  localparam int W    = aie_pkg::WORD_W;
  localparam int VI_W = $clog2(VARIABLE_COUNT);
  localparam int PC_W = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;

  aie_pkg::state_t     state_r, state_nxt;
  logic [W-1:0]        acc_r, acc_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic                halted_r, halted_nxt;
  logic [1:0]          code_r, code_nxt;
  logic [VI_W-1:0]     clr_cnt_r;
  aie_pkg::in_item_t   item_r;
  logic [VI_W-1:0]     item_vi_r;
  aie_pkg::out_item_t  res_r, res_nxt;
  aie_pkg::out_item_t  out_r;
  logic                out_valid_r;

  logic [W-1:0]        mem [VARIABLE_COUNT];
  logic [W-1:0]        rd_data_r;
  logic                mem_we;
  logic [VI_W-1:0]     mem_waddr;
  logic [W-1:0]        mem_wdata;

  logic [VI_W-1:0]     vi_tab  [aie_pkg::VAR_INDEX_CODES];
  logic [PC_W-1:0]     tgt_tab [aie_pkg::TARGET_CODES];
  logic [VI_W-1:0]     in_vi;
  logic [PC_W-1:0]     target;
  logic [PC_W-1:0]     pc_inc;
  logic [W-1:0]        operand;
  logic                accept;
  logic                out_free;
  logic                md_done;
  logic [W-1:0]        md_result;
  aie_pkg::md_req_t    md_req;

  for (genvar g = 0; g < aie_pkg::VAR_INDEX_CODES; g++) begin : g_vi
    assign vi_tab[g] = VI_W'(g % VARIABLE_COUNT);
  end

  for (genvar g = 0; g < aie_pkg::TARGET_CODES; g++) begin : g_tgt
    assign tgt_tab[g] = PC_W'(g % PROGRAM_DEPTH);
  end

  assign in_vi    = vi_tab[in_data.var_index];
  assign target   = tgt_tab[item_r.branch_target];
  assign pc_inc   = (pc_r == PC_W'(PROGRAM_DEPTH - 1)) ? PC_W'(0) : pc_r + 1'b1;
  assign operand  = item_r.use_immediate ? item_r.immediate_value : rd_data_r;
  assign in_ready = (state_r == aie_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  aie_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .done   (md_done),
    .result (md_result)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[in_vi];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aie_pkg::S_CLEAR;
      acc_r       <= '0;
      pc_r        <= '0;
      halted_r    <= 1'b0;
      code_r      <= aie_pkg::STAT_RUN;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      pc_r     <= pc_nxt;
      halted_r <= halted_nxt;
      code_r   <= code_nxt;
      if (state_r == aie_pkg::S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == aie_pkg::S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= in_data;
      item_vi_r <= in_vi;
    end
    res_r <= res_nxt;
    if (state_r == aie_pkg::S_OUT && out_free) begin
      out_r <= res_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    pc_nxt     = pc_r;
    halted_nxt = halted_r;
    code_nxt   = code_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = item_vi_r;
    mem_wdata  = acc_r;
    md_req     = '{start: 1'b0, is_div: 1'b0, op_a: acc_r, op_b: operand};
    unique case (state_r)
      aie_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == VI_W'(VARIABLE_COUNT - 1)) begin
          state_nxt = aie_pkg::S_IDLE;
        end
      end
      aie_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = aie_pkg::S_EXEC;
        end
      end
      aie_pkg::S_EXEC: begin
        state_nxt = aie_pkg::S_OUT;
        res_nxt.print_valid = 1'b0;
        res_nxt.print_value = '0;
        res_nxt.status      = aie_pkg::STAT_RUN;
        if (halted_r) begin
          res_nxt.status = code_r;
        end else begin
          pc_nxt = pc_inc;
          unique case (item_r.opcode)
            aie_pkg::OP_LOAD: acc_nxt = operand;
            aie_pkg::OP_STORE: mem_we = 1'b1;
            aie_pkg::OP_ADD: acc_nxt = acc_r + operand;
            aie_pkg::OP_SUB: acc_nxt = acc_r - operand;
            aie_pkg::OP_MULT: begin
              md_req.start = 1'b1;
              state_nxt    = aie_pkg::S_WAIT;
            end
            aie_pkg::OP_DIV: begin
              if (operand == '0) begin
                res_nxt.status = aie_pkg::STAT_DIV0;
              end else begin
                md_req.start  = 1'b1;
                md_req.is_div = 1'b1;
                state_nxt     = aie_pkg::S_WAIT;
              end
            end
            aie_pkg::OP_BG: begin
              if (acc_r != '0 && !acc_r[W-1]) begin
                pc_nxt = target;
              end
            end
            aie_pkg::OP_BE: begin
              if (acc_r == '0) begin
                pc_nxt = target;
              end
            end
            aie_pkg::OP_BL: begin
              if (acc_r[W-1]) begin
                pc_nxt = target;
              end
            end
            aie_pkg::OP_BU: pc_nxt = target;
            aie_pkg::OP_READ: begin
              mem_we    = 1'b1;
              mem_wdata = item_r.read_value;
            end
            aie_pkg::OP_PRINT: begin
              res_nxt.print_valid = 1'b1;
              res_nxt.print_value = rd_data_r;
            end
            aie_pkg::OP_DC: begin
              mem_we    = 1'b1;
              mem_wdata = item_r.immediate_value;
            end
            aie_pkg::OP_END: res_nxt.status = aie_pkg::STAT_END;
            default: res_nxt.status = aie_pkg::STAT_BADOP;
          endcase
          if (res_nxt.status != aie_pkg::STAT_RUN) begin
            halted_nxt = 1'b1;
            code_nxt   = res_nxt.status;
            pc_nxt     = pc_r;
            acc_nxt    = acc_r;
          end
        end
        res_nxt.next_pc   = 8'(pc_nxt);
        res_nxt.acc_value = acc_nxt;
      end
      aie_pkg::S_WAIT: begin
        if (md_done) begin
          acc_nxt           = md_result;
          res_nxt.acc_value = md_result;
          state_nxt         = aie_pkg::S_OUT;
        end
      end
      aie_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = aie_pkg::S_IDLE;
        end
      end
      default: state_nxt = aie_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
